// ===== sv/u16u8_pkg.sv =====
`timescale 1ns / 1ps

package u16u8_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int MAX_BYTES   = 6;

    localparam logic [15:0] HIGH_FIRST  = 16'hD800;
    localparam logic [15:0] HIGH_LAST   = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST   = 16'hDC00;
    localparam logic [15:0] LOW_LAST    = 16'hDFFF;
    localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
    localparam logic [20:0] SUPP_BASE   = 21'h010000;
    localparam logic [20:0] MAX_ONE     = 21'h00007F;
    localparam logic [20:0] MAX_TWO     = 21'h0007FF;
    localparam logic [20:0] MAX_THREE   = 21'h00FFFF;
    localparam logic [7:0]  LEAD_TWO    = 8'hC0;
    localparam logic [7:0]  LEAD_THREE  = 8'hE0;
    localparam logic [7:0]  LEAD_FOUR   = 8'hF0;
    localparam logic [7:0]  CONT_MARK   = 8'h80;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_unit;
    } unit_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_end;
    } byte_t;

    // One queued job: the byte run caused by one unit, first byte at index 0.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                count;
        logic                      last;
    } job_t;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      len;
    } enc_t;

    function automatic enc_t encode_cp(input logic [20:0] cp);
        enc_t e;
        e.b = '0;
        if (cp <= MAX_ONE) begin
            e.len  = 3'd1;
            e.b[0] = cp[7:0];
        end else if (cp <= MAX_TWO) begin
            e.len  = 3'd2;
            e.b[0] = LEAD_TWO | {3'b000, cp[10:6]};
            e.b[1] = CONT_MARK | {2'b00, cp[5:0]};
        end else if (cp <= MAX_THREE) begin
            e.len  = 3'd3;
            e.b[0] = LEAD_THREE | {4'b0000, cp[15:12]};
            e.b[1] = CONT_MARK | {2'b00, cp[11:6]};
            e.b[2] = CONT_MARK | {2'b00, cp[5:0]};
        end else begin
            e.len  = 3'd4;
            e.b[0] = LEAD_FOUR | {5'b00000, cp[20:18]};
            e.b[1] = CONT_MARK | {2'b00, cp[17:12]};
            e.b[2] = CONT_MARK | {2'b00, cp[11:6]};
            e.b[3] = CONT_MARK | {2'b00, cp[5:0]};
        end
        return e;
    endfunction

endpackage

// ===== sv/utf16_to_utf8_transcoder.sv =====
// UTF-16 to UTF-8 transcoder: one code unit in, zero to six bytes out.
// With queue and output empty, the first byte of a unit passes through the queue write
// and then the load of the output register before it is valid.
// Throughput: a word is taken every cycle while the job queue has room; the back end
// sends one byte per cycle while byte_ready is high.
// Reset (rst_n low, async): no held surrogate, job queue empty, output idle.
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder #(
    parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             unit_valid,
    output logic             unit_ready,
    input  u16u8_pkg::unit_t unit_word,
    output logic             byte_valid,
    input  logic             byte_ready,
    output u16u8_pkg::byte_t byte_word
);
    import u16u8_pkg::*;

    // Front end: surrogate pairing and classification, building the whole byte
    // run of a unit at once. A high surrogate mid-string is held and queues no bytes of its own.
    logic  push, pop, full, nonempty;
    job_t  job_in, job_head;

    u16u8_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .unit_valid (unit_valid),
        .unit_ready (unit_ready),
        .unit_word  (unit_word),
        .queue_full (full),
        .push       (push),
        .job        (job_in)
    );

    // Short job queue: lets the front take the next word while bytes drain.
    u16u8_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wdata    (job_in),
        .full     (full),
        .pop      (pop),
        .rdata    (job_head),
        .nonempty (nonempty)
    );

    // Back end: walk the head run one byte per cycle, when not stalled by byte_ready, into the
    // output register, marking the run's last byte and, for the final unit, the string end.
    u16u8_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .nonempty   (nonempty),
        .head       (job_head),
        .pop        (pop),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_word  (byte_word)
    );

endmodule

// ===== sv/u16u8_front.sv =====
`timescale 1ns / 1ps

module u16u8_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             unit_valid,
    output logic             unit_ready,
    input  u16u8_pkg::unit_t unit_word,
    input  logic             queue_full,
    output logic             push,
    output u16u8_pkg::job_t  job
);
    import u16u8_pkg::*;

    logic       pending_reg, pending_next;
    logic [9:0] high_bits_reg, high_bits_next;
    logic       accept, is_high, is_low, prefix, pair;
    logic [20:0] cp;
    logic        main_none;
    enc_t        main_enc, fffd_enc;
    logic [2:0]  main_len;

    assign unit_ready = !queue_full;
    assign accept     = unit_valid && unit_ready;
    assign is_high    = unit_word.code_unit >= HIGH_FIRST && unit_word.code_unit <= HIGH_LAST;
    assign is_low     = unit_word.code_unit >= LOW_FIRST && unit_word.code_unit <= LOW_LAST;
    assign pair       = pending_reg && is_low;
    assign prefix     = pending_reg && !is_low;
    // A high surrogate mid-string is held and makes no bytes yet.
    assign main_none  = is_high && !unit_word.last_unit;

    always_comb
    begin
        priority if (pair)
            cp = SUPP_BASE + {1'b0, high_bits_reg, unit_word.code_unit[9:0]};
        else if (is_high || is_low)
            cp = REPLACEMENT;
        else
            cp = {5'd0, unit_word.code_unit};
    end

    assign main_enc = encode_cp(cp);
    assign fffd_enc = encode_cp(REPLACEMENT);
    assign main_len = main_none ? 3'd0 : main_enc.len;

    always_comb
    begin
        // With a prefix the unit itself never needs more than three bytes.
        if (prefix)
            job.bytes = {main_enc.b[2:0], fffd_enc.b[2:0]};
        else
            job.bytes = {16'h0000, main_enc.b};
        job.count = prefix ? 3'(main_len + 3'd3) : main_len;
        job.last  = unit_word.last_unit;
    end

    assign push = accept && (job.count != 3'd0);

    always_comb
    begin
        pending_next   = pending_reg;
        high_bits_next = high_bits_reg;
        if (accept)
        begin
            pending_next   = main_none;
            high_bits_next = main_none ? unit_word.code_unit[9:0] : 10'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 1'b0;
            high_bits_reg <= 10'd0;
        end
        else
        begin
            pending_reg   <= pending_next;
            high_bits_reg <= high_bits_next;
        end
    end

    a_end_clears_hold: assert property (@(posedge clk) disable iff (!rst_n)
        accept && unit_word.last_unit |=> !pending_reg)
        else $error("surrogate still held after end of string");

    a_last_makes_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && unit_word.last_unit |-> push)
        else $error("end of string produced no bytes");

endmodule

// ===== sv/u16u8_fifo.sv =====
`timescale 1ns / 1ps

module u16u8_fifo #(
    parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  u16u8_pkg::job_t wdata,
    output logic            full,
    input  logic            pop,
    output u16u8_pkg::job_t rdata,
    output logic            nonempty
);
    import u16u8_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t            mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full     = count_reg == CW'(DEPTH);
    assign nonempty = count_reg != '0;
    assign rdata    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_reg + 1'b1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_reg + 1'b1);
        count_next = CW'(count_reg + CW'(push) - CW'(pop));
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

endmodule

// ===== sv/u16u8_back.sv =====
`timescale 1ns / 1ps

module u16u8_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             nonempty,
    input  u16u8_pkg::job_t  head,
    output logic             pop,
    output logic             byte_valid,
    input  logic             byte_ready,
    output u16u8_pkg::byte_t byte_word
);
    import u16u8_pkg::*;

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    byte_t      word_reg, word_next;
    logic       load, final_byte;

    // When the queue holds a job, refill the output register whenever it is empty or being drained.
    assign load       = nonempty && (!valid_reg || byte_ready);
    assign final_byte = idx_reg == 3'(head.count - 3'd1);
    assign pop        = load && final_byte;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        word_next  = word_reg;
        if (load)
        begin
            word_next.out_byte   = head.bytes[idx_reg];
            word_next.run_last   = final_byte;
            word_next.string_end = final_byte && head.last;
            valid_next           = 1'b1;
            idx_next             = final_byte ? 3'd0 : 3'(idx_reg + 3'd1);
        end
        else if (byte_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign byte_valid = valid_reg;
    assign byte_word  = word_reg;

    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        nonempty |-> idx_reg < head.count)
        else $error("byte index past end of run");

    a_end_on_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && word_reg.string_end |-> word_reg.run_last)
        else $error("string end on a byte that does not close its run");

endmodule
